### src/aes256_cbc_encrypt_assert.svh
// Assertion macros shared by the checker.
// No dependencies.
`ifndef AES256_CBC_ENCRYPT_ASSERT_SVH
`define AES256_CBC_ENCRYPT_ASSERT_SVH
`define A_IMPL(lbl, clk, rst, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (a) |-> (c)) \
        else $error("assertion failed");
`define A_NEXT(lbl, clk, rst, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### src/aes_pkg.sv
// Package for the AES-256 CBC block: constants, S-box, round helpers.
// No dependencies.
package aes_pkg;
    localparam int NUM_ROUNDS_DEF = 14;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IVH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IVL  = 3'd5;

    typedef enum logic [1:0] {
        t_idle = 2'd0, t_expand = 2'd1, t_run = 2'd2
    } t_state;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
        return t[x];
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] rcon(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd1: r = 8'h01;
            3'd2: r = 8'h02;
            3'd3: r = 8'h04;
            3'd4: r = 8'h08;
            3'd5: r = 8'h10;
            3'd6: r = 8'h20;
            3'd7: r = 8'h40;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    // Byte k of the state sits at bits 127-8k.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(4*c+r) -: 8] = sbox(s[127-8*(4*((c+r)%4)+r) -: 8]);
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127-32*c -: 8] = a0 ^ al ^ dbl(a0 ^ a1);
            t[119-32*c -: 8] = a1 ^ al ^ dbl(a1 ^ a2);
            t[111-32*c -: 8] = a2 ^ al ^ dbl(a2 ^ a3);
            t[103-32*c -: 8] = a3 ^ al ^ dbl(a3 ^ a0);
        end
        return t;
    endfunction
endpackage

### src/aes256_cbc_encrypt.sv
// AES-256 CBC encryptor, top level with round-key memory and round loop.
// Depends on aes_pkg.
//
//  channel | dir | handshake          | payload
//  in      | in  | i_valid / o_ready  | plaintext_high/low, start_of_message
//  out     | out | o_valid / i_ready  | ciphertext_high/low
//  cfg     | in  | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// An accepted item first gets round key 0 added, then runs the 14 rounds, each
// round key read ahead into a register from the 4-word-wide key memory. A new
// item is taken only once the last one has finished its rounds. A key write
// leads to a set-up step storing the key rows, then the expansion, one word per
// cycle; items wait meanwhile. Reset is synchronous and clears control, key, IV
// and chaining state. The next item is taken once the result has left the
// output register or is taken in the same cycle.
module aes256_cbc_encrypt #(
    parameter int NUM_ROUNDS = aes_pkg::NUM_ROUNDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [63:0]                    i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [63:0]                    i_plaintext_high,
    input  logic [63:0]                    i_plaintext_low,
    input  logic                           i_start_of_message,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [63:0]                    o_ciphertext_high,
    output logic [63:0]                    o_ciphertext_low
);
    import aes_pkg::*;

    localparam int WORDS = 4 * (NUM_ROUNDS + 1);
    localparam int WA_W  = $clog2(WORDS);
    localparam int RA_W  = $clog2(NUM_ROUNDS + 1);

    logic [255:0] r_key;
    logic [127:0] r_iv, r_chain, r_st, n_st;
    logic [31:0]  r_win [8];      // sliding window of the last eight words
    logic [127:0] r_mem [NUM_ROUNDS+1];
    logic [127:0] r_rk;
    logic [31:0]  r_acc [3];      // words of the row being assembled
    t_state       r_state, n_state;
    logic [WA_W-1:0] r_wi, n_wi;
    logic [RA_W-1:0] r_rd, n_rd, r_round, n_round;
    logic         r_pend, n_pend, r_ov, n_ov, r_first, n_first;
    logic         key_wr, acc_in, acc_out, mem_we;
    logic [31:0]  new_w, tw;
    logic [127:0] ld;

    assign key_wr  = i_cfg_we && (i_cfg_idx == REG_KEY0 || i_cfg_idx == REG_KEY1 ||
                                  i_cfg_idx == REG_KEY2 || i_cfg_idx == REG_KEY3);
    assign acc_out = r_ov && i_ready;
    assign o_ready = (r_state == t_idle) && !r_pend && !key_wr && (!r_ov || i_ready);
    assign acc_in  = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_ciphertext_high = r_chain[127:64];
    assign o_ciphertext_low  = r_chain[63:0];

    // next key word from the window; r_wi is the word index being produced
    always_comb begin
        tw = r_win[7];
        if (r_wi[2:0] == 3'd0) tw = sbox_word({tw[23:0], tw[31:24]}) ^ {rcon(r_wi[5:3]), 24'd0};
        else if (r_wi[2:0] == 3'd4) tw = sbox_word(tw);
        new_w = r_win[0] ^ tw;
    end

    assign mem_we = (r_state == t_expand) && (r_wi[1:0] == 2'd3);
    assign ld = {i_plaintext_high, i_plaintext_low} ^ (i_start_of_message ? r_iv : r_chain);

    always_comb begin
        n_state = r_state; n_wi = r_wi; n_rd = r_rd; n_round = r_round;
        n_pend = r_pend || key_wr; n_ov = r_ov && !i_ready; n_first = r_first;
        n_st = r_st;
        unique case (r_state)
            t_idle: begin
                if (r_pend && !key_wr) begin
                    n_state = t_expand; n_wi = WA_W'(8); n_pend = 1'b0;
                end else if (acc_in) begin
                    n_state = t_run; n_rd = RA_W'(1); n_round = '0; n_first = 1'b1;
                    n_st = ld;
                end
            end
            t_expand: begin
                if (r_wi == WA_W'(WORDS - 1)) n_state = t_idle;
                else n_wi = r_wi + WA_W'(1);
            end
            t_run: begin
                // r_rk holds round key r_round
                n_first = 1'b0;
                if (r_first) begin
                    n_st = r_st ^ r_rk;
                end else if (r_round == RA_W'(NUM_ROUNDS)) begin
                    n_st = sub_shift(r_st) ^ r_rk;
                end else begin
                    n_st = mix(sub_shift(r_st)) ^ r_rk;
                end
                if (!r_first) begin
                    if (r_round == RA_W'(NUM_ROUNDS)) begin
                        n_state = t_idle; n_ov = 1'b1;
                    end
                end
                if (!r_first || r_round != '0) n_round = r_round + RA_W'(1);
                if (r_first) n_round = RA_W'(1);
                if (r_rd != RA_W'(NUM_ROUNDS)) n_rd = r_rd + RA_W'(1);
            end
            default: n_state = t_idle;
        endcase
    end

    // key memory: one 4-word row per round, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_wi[WA_W-1:2]] <= {r_acc[0], r_acc[1], r_acc[2], new_w};
        if (r_state == t_idle && r_pend && !key_wr) begin
            r_mem[0] <= r_key[255:128];
            r_mem[1] <= r_key[127:0];
        end
        r_rk <= r_mem[(r_state == t_idle) ? RA_W'(0) : r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == t_idle) begin
            for (int k = 0; k < 8; k++) r_win[k] <= r_key[255-32*k -: 32];
        end else if (r_state == t_expand) begin
            for (int k = 0; k < 7; k++) r_win[k] <= r_win[k+1];
            r_win[7] <= new_w;
            r_acc[r_wi[1:0] == 2'd3 ? 2'd0 : r_wi[1:0]] <= new_w;
        end
        if (!i_rst_n) begin
            r_state <= t_idle; r_ov <= 1'b0; r_pend <= 1'b0; r_first <= 1'b0;
            r_key <= '0; r_iv <= '0; r_chain <= '0;
            r_wi <= '0; r_rd <= '0; r_round <= '0;
        end else begin
            r_state <= n_state; r_ov <= n_ov; r_pend <= n_pend; r_first <= n_first;
            r_wi <= n_wi; r_rd <= n_rd; r_round <= n_round;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KEY0: r_key[255:192] <= i_cfg_data;
                    REG_KEY1: r_key[191:128] <= i_cfg_data;
                    REG_KEY2: r_key[127:64]  <= i_cfg_data;
                    REG_KEY3: r_key[63:0]    <= i_cfg_data;
                    REG_IVH:  r_iv[127:64]   <= i_cfg_data;
                    REG_IVL:  r_iv[63:0]     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == t_run && !r_first && r_round == RA_W'(NUM_ROUNDS))
                r_chain <= n_st;
        end
        r_st <= n_st;
    end
endmodule

### src/aes_chk.sv
// Port-level checker for the AES-256 CBC encryptor, bound to the top level.
// Depends on aes256_cbc_encrypt_assert.svh.
`include "aes256_cbc_encrypt_assert.svh"
module aes_chk (
    input logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready,
    input logic [63:0] o_ciphertext_high, o_ciphertext_low
);
    `A_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_ciphertext_high))
    `A_NEXT(a_no_back, i_clk, i_rst_n, i_valid && o_ready, !o_ready && !o_valid)
    `A_IMPL(a_rdy_out, i_clk, i_rst_n, o_ready && o_valid, i_ready)
endmodule

bind aes256_cbc_encrypt aes_chk u_chk (.*);
